>>> hw/rtl/bqiir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqiir_pkg
// Shared widths, codes, types and saturation helpers of the biquad cascade.
// ----------------------------------------------------------------------------
package bqiir_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int COEF_W           = 32;
  localparam int INT_W            = 40;
  localparam int LO_W             = 16;
  localparam int HALF_W           = 25;
  localparam int PROD_W           = COEF_W + HALF_W;
  localparam int SUM_W            = PROD_W + LO_W + 1;
  localparam int RND_W            = 44;
  localparam int ACC_W            = 46;
  localparam int COEF_SHIFT       = 29;
  localparam int GAIN_SHIFT       = 21;
  localparam int OUT_SHIFT        = 8;
  localparam int OUT_PRE_W        = INT_W + 1 - OUT_SHIFT;
  localparam int COEFS            = 5;
  localparam int MAX_SECTIONS_DEF = 8;
  localparam int SEL_W            = 3;
  localparam int SEC_IN_W         = 3;
  localparam int ACT_W            = 4;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 1;
  localparam int STEP_W           = 4;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SECTIONS = 1'b1;

  localparam logic signed [COEF_W-1:0] GAIN_RESET   = 32'sh2000_0000;
  localparam logic [ACT_W-1:0]         ACTIVE_RESET = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_LOAD,
    ST_SEC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic issue;
    logic lo;
    logic neg;
    logic load;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic                    clip;
    logic signed [INT_W-1:0] val;
  } sat_int_t;

  typedef struct packed {
    logic                       clip;
    logic signed [SAMPLE_W-1:0] val;
  } sat_out_t;

  function automatic sat_int_t sat_int(input logic signed [ACC_W-1:0] v);
    sat_int_t r;
    if (v[ACC_W-1:INT_W-1] == '0 || v[ACC_W-1:INT_W-1] == '1) begin
      r.clip = 1'b0;
      r.val  = v[INT_W-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = v[ACC_W-1] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic sat_out_t sat_out(input logic signed [OUT_PRE_W-1:0] v);
    sat_out_t r;
    if (v[OUT_PRE_W-1:SAMPLE_W-1] == '0 || v[OUT_PRE_W-1:SAMPLE_W-1] == '1) begin
      r.clip = 1'b0;
      r.val  = v[SAMPLE_W-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = v[OUT_PRE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                              : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bqiir_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqiir_mac
// Shared 32x25 multiplier with split-operand rounding and accumulator.
// A 32x40 product is issued as high half then low half on back-to-back
// cycles; product, rounded sum and accumulator are registered in that order.
// ----------------------------------------------------------------------------
module bqiir_mac (
  input  logic                                      clk,
  input  logic                                      rst,
  input  bqiir_pkg::mac_ctl_t                       ctl,
  input  logic signed [bqiir_pkg::COEF_W-1:0]       coef,
  input  logic signed [bqiir_pkg::HALF_W-1:0]       half,
  input  logic signed [bqiir_pkg::ACC_W-1:0]        load_value,
  output logic signed [bqiir_pkg::PROD_W-1:0]       product,
  output logic signed [bqiir_pkg::ACC_W-1:0]        acc
);

  logic                                   s1_issue;
  logic                                   s1_lo;
  logic                                   s1_neg;
  logic signed [bqiir_pkg::PROD_W-1:0]    hold;
  logic signed [bqiir_pkg::SUM_W-1:0]     sum;
  logic signed [bqiir_pkg::RND_W-1:0]     rnd;
  logic                                   rnd_valid;
  logic                                   rnd_neg;
  logic signed [bqiir_pkg::ACC_W-1:0]     acc_next;

  // multiply stage
  always_ff @(posedge clk) begin
    product <= bqiir_pkg::PROD_W'(coef * half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_issue <= 1'b0;
      s1_lo    <= 1'b0;
      s1_neg   <= 1'b0;
    end else begin
      s1_issue <= ctl.issue;
      s1_lo    <= ctl.lo;
      s1_neg   <= ctl.neg;
    end
  end

  // combine halves and round
  always_comb begin
    sum = (bqiir_pkg::SUM_W'(hold) <<< bqiir_pkg::LO_W) + bqiir_pkg::SUM_W'(product)
        + (bqiir_pkg::SUM_W'(1) <<< (bqiir_pkg::COEF_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (s1_issue && !s1_lo) begin
      hold <= product;
    end
    rnd <= sum[bqiir_pkg::COEF_SHIFT +: bqiir_pkg::RND_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
      rnd_neg   <= 1'b0;
    end else begin
      rnd_valid <= s1_issue && s1_lo;
      rnd_neg   <= s1_neg;
    end
  end

  // load, clear or accumulate
  always_comb begin
    acc_next = acc;
    if (ctl.load) begin
      acc_next = load_value;
    end else if (ctl.clear) begin
      acc_next = '0;
    end else if (rnd_valid) begin
      acc_next = rnd_neg ? acc - bqiir_pkg::ACC_W'(rnd) : acc + bqiir_pkg::ACC_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  a_lo_after_hi: assert property (@(posedge clk) disable iff (rst)
    (ctl.issue && ctl.lo) |-> $past(ctl.issue && !ctl.lo))
    else $error("low half issued without its high half");

  a_no_add_lost: assert property (@(posedge clk) disable iff (rst)
    (ctl.load || ctl.clear) |-> !rnd_valid)
    else $error("accumulator overwritten while a product is pending");

endmodule

>>> hw/rtl/biquad_cascade_iir_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter
// Direct Form II biquad cascade, Q1.23 samples, Q3.29 coefficients and gain.
//
//   channel  direction  handshake           payload
//   in       into block in_valid/in_stall   op, sample_in, section_index,
//                                           coef_select, coef_value
//   out      from block out_valid/out_stall sample_out, clipped
//   cfg      into block cfg_we              cfg_index, cfg_data
//
// A sample passes the gain and load states, the section steps of each of N
// active sections (at most MAX_SECTIONS) and the output state; the single 32x25
// multiplier builds each 32x40 product from two halves. Reset makes all
// coefficients read as zero and clears delays and control registers; no
// clearing pass is needed. in_stall is high while a sample is in work; a held
// result only stalls the next sample in its output state.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter #(
  parameter int MAX_SECTIONS = bqiir_pkg::MAX_SECTIONS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       op,
  input  logic signed [bqiir_pkg::SAMPLE_W-1:0]      sample_in,
  input  logic [bqiir_pkg::SEC_IN_W-1:0]             section_index,
  input  logic [bqiir_pkg::SEL_W-1:0]                coef_select,
  input  logic signed [bqiir_pkg::COEF_W-1:0]        coef_value,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [bqiir_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                                       clipped,
  input  logic                                       cfg_we,
  input  logic [bqiir_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [bqiir_pkg::CFG_W-1:0]                cfg_data
);

  localparam int DEPTH  = bqiir_pkg::COEFS * MAX_SECTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_SECTIONS + 1);
  localparam int IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int NW     = (CNT_W > bqiir_pkg::ACT_W) ? CNT_W : bqiir_pkg::ACT_W;
  localparam int WA_W   = ADDR_W + 3;
  localparam int INT_W  = bqiir_pkg::INT_W;
  localparam int HALF_W = bqiir_pkg::HALF_W;
  localparam int LO_W   = bqiir_pkg::LO_W;

  localparam logic [bqiir_pkg::STEP_W-1:0] STEP_FIRST     = 4'd1;
  localparam logic [bqiir_pkg::STEP_W-1:0] STEP_NEG_END   = 4'd4;
  localparam logic [bqiir_pkg::STEP_W-1:0] STEP_W_SAT     = 4'd7;
  localparam logic [bqiir_pkg::STEP_W-1:0] STEP_ISSUE_END = 4'd10;
  localparam logic [bqiir_pkg::STEP_W-1:0] STEP_LAST      = 4'd13;

  typedef enum logic [1:0] {
    SRC_D1,
    SRC_D2,
    SRC_W
  } dsrc_t;

  bqiir_pkg::state_t state, state_next;

  logic signed [bqiir_pkg::COEF_W-1:0]   input_gain;
  logic [bqiir_pkg::ACT_W-1:0]           active_sections;
  logic [NW-1:0]                         act_wide;
  logic [NW-1:0]                         n_eff;
  logic [NW-1:0]                         sec_cnt;
  logic                                  sec_last;
  logic [bqiir_pkg::STEP_W-1:0]          step;
  logic [ADDR_W:0]                       base;
  logic signed [bqiir_pkg::SAMPLE_W-1:0] sample_q;
  logic                                  clip;

  logic signed [bqiir_pkg::COEF_W-1:0]   coef_mem [DEPTH];
  logic [DEPTH-1:0]                      coef_vld;
  logic signed [bqiir_pkg::COEF_W-1:0]   coef_q;
  logic                                  coef_vld_q;
  logic signed [bqiir_pkg::COEF_W-1:0]   coef_rd;
  logic [WA_W-1:0]                       wr_addr_w;
  logic                                  coef_we;
  logic [ADDR_W+1:0]                     rd_sum;
  logic [ADDR_W-1:0]                     rd_addr;
  logic [bqiir_pkg::SEL_W-1:0]           rd_sel;

  logic signed [INT_W-1:0]               d1s [MAX_SECTIONS];
  logic signed [INT_W-1:0]               d2s [MAX_SECTIONS];
  logic signed [INT_W-1:0]               d1;
  logic signed [INT_W-1:0]               d2;
  logic signed [INT_W-1:0]               w_reg;
  logic signed [INT_W-1:0]               ybuf;
  logic signed [INT_W-1:0]               dsrc_val;
  dsrc_t                                 dsrc;

  bqiir_pkg::mac_ctl_t                   ctl;
  logic                                  gain_mode;
  logic signed [bqiir_pkg::COEF_W-1:0]   mac_coef;
  logic signed [HALF_W-1:0]              mac_half;
  logic signed [bqiir_pkg::ACC_W-1:0]    mac_load;
  logic signed [bqiir_pkg::PROD_W-1:0]   mac_product;
  logic signed [bqiir_pkg::ACC_W-1:0]    mac_acc;

  logic signed [bqiir_pkg::PROD_W:0]     gsum;
  bqiir_pkg::sat_int_t                   y0_sat;
  bqiir_pkg::sat_int_t                   acc_sat;
  logic signed [INT_W:0]                 out_sum;
  bqiir_pkg::sat_out_t                   o_sat;

  logic                                  in_accept;
  logic                                  out_free;
  logic                                  out_load;

  function automatic logic [bqiir_pkg::SEL_W-1:0] read_sel(
    input logic [bqiir_pkg::STEP_W-1:0] k
  );
    case (k)
      4'd2, 4'd3: read_sel = bqiir_pkg::COEF_A2;
      4'd4, 4'd5: read_sel = bqiir_pkg::COEF_B1;
      4'd6, 4'd7: read_sel = bqiir_pkg::COEF_B2;
      4'd8, 4'd9: read_sel = bqiir_pkg::COEF_B0;
      default:    read_sel = bqiir_pkg::COEF_A1;
    endcase
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign act_wide  = NW'(active_sections);
  assign n_eff     = (act_wide > NW'(MAX_SECTIONS)) ? NW'(MAX_SECTIONS) : act_wide;
  assign sec_last  = (sec_cnt + NW'(1)) == n_eff;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain      <= bqiir_pkg::GAIN_RESET;
      active_sections <= bqiir_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bqiir_pkg::REG_INPUT_GAIN:      input_gain      <= cfg_data;
        bqiir_pkg::REG_ACTIVE_SECTIONS: active_sections <= cfg_data[bqiir_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient store
  assign wr_addr_w = WA_W'(section_index) * WA_W'(bqiir_pkg::COEFS) + WA_W'(coef_select);
  assign coef_we   = in_accept && op == bqiir_pkg::OP_COEF
                  && coef_select < bqiir_pkg::SEL_W'(bqiir_pkg::COEFS)
                  && WA_W'(section_index) < WA_W'(MAX_SECTIONS);

  always_comb begin
    rd_sel = read_sel(step);
    rd_sum = (ADDR_W+2)'(base) + (ADDR_W+2)'(rd_sel);
    if (state == bqiir_pkg::ST_SEC && step == STEP_LAST) begin
      rd_sum = rd_sum + (ADDR_W+2)'(bqiir_pkg::COEFS);
    end
    rd_addr = (rd_sum < (ADDR_W+2)'(DEPTH)) ? rd_sum[ADDR_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[wr_addr_w[ADDR_W-1:0]] <= coef_value;
    end
    coef_q     <= coef_mem[rd_addr];
    coef_vld_q <= coef_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (coef_we) begin
      coef_vld[wr_addr_w[ADDR_W-1:0]] <= 1'b1;
    end
  end

  assign coef_rd = coef_vld_q ? coef_q : '0;

  // delay line per section
  assign d1 = d1s[sec_cnt[IDX_W-1:0]];
  assign d2 = d2s[sec_cnt[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        d1s[i] <= '0;
        d2s[i] <= '0;
      end
    end else if (state == bqiir_pkg::ST_SEC && step == STEP_LAST) begin
      d1s[sec_cnt[IDX_W-1:0]] <= w_reg;
      d2s[sec_cnt[IDX_W-1:0]] <= d1;
    end
  end

  // arithmetic around the shared unit
  assign gsum    = (bqiir_pkg::PROD_W+1)'(mac_product)
                 + ((bqiir_pkg::PROD_W+1)'(1) <<< (bqiir_pkg::GAIN_SHIFT - 1));
  assign y0_sat  = bqiir_pkg::sat_int(
                     bqiir_pkg::ACC_W'(signed'(gsum[bqiir_pkg::PROD_W:bqiir_pkg::GAIN_SHIFT])));
  assign acc_sat = bqiir_pkg::sat_int(mac_acc);
  assign out_sum = (INT_W+1)'(ybuf) + ((INT_W+1)'(1) <<< (bqiir_pkg::OUT_SHIFT - 1));
  assign o_sat   = bqiir_pkg::sat_out(signed'(out_sum[INT_W:bqiir_pkg::OUT_SHIFT]));

  always_comb begin
    case (dsrc)
      SRC_D1:  dsrc_val = d1;
      SRC_D2:  dsrc_val = d2;
      SRC_W:   dsrc_val = w_reg;
      default: dsrc_val = w_reg;
    endcase
  end

  always_comb begin
    if (gain_mode) begin
      mac_coef = input_gain;
      mac_half = HALF_W'(sample_q);
    end else if (ctl.lo) begin
      mac_coef = coef_rd;
      mac_half = {{(HALF_W-LO_W){1'b0}}, dsrc_val[LO_W-1:0]};
    end else begin
      mac_coef = coef_rd;
      mac_half = HALF_W'(signed'(dsrc_val[INT_W-1:LO_W]));
    end
  end

  assign mac_load = (state == bqiir_pkg::ST_LOAD) ? bqiir_pkg::ACC_W'(y0_sat.val)
                                                   : bqiir_pkg::ACC_W'(acc_sat.val);

  bqiir_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .coef       (mac_coef),
    .half       (mac_half),
    .load_value (mac_load),
    .product    (mac_product),
    .acc        (mac_acc)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      bqiir_pkg::ST_IDLE: begin
        if (in_accept && op == bqiir_pkg::OP_FILTER) begin
          state_next = bqiir_pkg::ST_GAIN;
        end
      end
      bqiir_pkg::ST_GAIN: state_next = bqiir_pkg::ST_LOAD;
      bqiir_pkg::ST_LOAD: begin
        state_next = (n_eff == '0) ? bqiir_pkg::ST_OUT : bqiir_pkg::ST_SEC;
      end
      bqiir_pkg::ST_SEC: begin
        if (step == STEP_LAST && sec_last) begin
          state_next = bqiir_pkg::ST_OUT;
        end
      end
      bqiir_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = bqiir_pkg::ST_IDLE;
        end
      end
      default: state_next = bqiir_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    gain_mode = 1'b0;
    out_load  = 1'b0;
    ctl       = '0;
    dsrc      = SRC_W;
    case (state)
      bqiir_pkg::ST_IDLE: in_stall = 1'b0;
      bqiir_pkg::ST_GAIN: gain_mode = 1'b1;
      bqiir_pkg::ST_LOAD: ctl.load = 1'b1;
      bqiir_pkg::ST_SEC: begin
        ctl.issue = step >= STEP_FIRST && step <= STEP_ISSUE_END;
        ctl.lo    = !step[0];
        ctl.neg   = step <= STEP_NEG_END;
        ctl.clear = step == STEP_W_SAT;
        ctl.load  = step == STEP_LAST;
        case (step)
          4'd1, 4'd2, 4'd5, 4'd6: dsrc = SRC_D1;
          4'd3, 4'd4, 4'd7, 4'd8: dsrc = SRC_D2;
          default:                dsrc = SRC_W;
        endcase
      end
      bqiir_pkg::ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqiir_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      sec_cnt <= '0;
      base    <= '0;
      clip    <= 1'b0;
    end else begin
      case (state)
        bqiir_pkg::ST_IDLE: begin
          step    <= '0;
          sec_cnt <= '0;
          base    <= '0;
          clip    <= 1'b0;
        end
        bqiir_pkg::ST_LOAD: begin
          step <= STEP_FIRST;
          clip <= clip | y0_sat.clip;
        end
        bqiir_pkg::ST_SEC: begin
          if (step == STEP_LAST) begin
            step    <= STEP_FIRST;
            sec_cnt <= sec_cnt + NW'(1);
            base    <= base + (ADDR_W+1)'(bqiir_pkg::COEFS);
            clip    <= clip | acc_sat.clip;
          end else begin
            step <= step + 4'd1;
            if (step == STEP_W_SAT) begin
              clip <= clip | acc_sat.clip;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q <= sample_in;
    end
    if (state == bqiir_pkg::ST_LOAD) begin
      ybuf <= y0_sat.val;
    end else if (state == bqiir_pkg::ST_SEC && step == STEP_LAST) begin
      ybuf <= acc_sat.val;
    end
    if (state == bqiir_pkg::ST_SEC && step == STEP_W_SAT) begin
      w_reg <= acc_sat.val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= o_sat.val;
      clipped    <= clip | o_sat.clip;
    end
  end

  a_coef_write_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && op == bqiir_pkg::OP_COEF) |=> state == bqiir_pkg::ST_IDLE)
    else $error("coefficient write left the idle state");

  a_section_range: assert property (@(posedge clk) disable iff (rst)
    state == bqiir_pkg::ST_SEC |-> sec_cnt < n_eff)
    else $error("section counter beyond active sections");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == bqiir_pkg::ST_OUT && out_valid && out_stall) |=> state == bqiir_pkg::ST_OUT)
    else $error("result dropped while output register full");

endmodule

>>> verif/biquad_cascade_iir_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_tb
// Self-checking bench for the biquad cascade. A bit-exact fixed-point filter
// model runs beside the block and predicts each filtered sample and its clip
// flag. Directed tests cover reset defaults, every coefficient slot, ignored
// selects, zero and oversized section counts, gain extremes and internal
// overflow. Random phases then reprogram the gain, the section count and the
// coefficients and stream samples, with bursty input and random output stall.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter_tb;

  localparam int MAX_SECTIONS   = bqiir_pkg::MAX_SECTIONS_DEF;
  localparam int SETTLE_CYCLES  = 3 + 13 * MAX_SECTIONS + 16;
  localparam int WATCHDOG_LIMIT = 20 * SETTLE_CYCLES;

  localparam logic [bqiir_pkg::SEL_W-1:0] COEF_BAD_LO = 3'd5;
  localparam logic [bqiir_pkg::SEL_W-1:0] COEF_BAD_HI = 3'd7;

  typedef struct {
    logic signed [bqiir_pkg::SAMPLE_W-1:0] sample;
    logic                                  clip;
  } out_item_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic                                  op = bqiir_pkg::OP_FILTER;
  logic signed [bqiir_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic [bqiir_pkg::SEC_IN_W-1:0]        section_index = '0;
  logic [bqiir_pkg::SEL_W-1:0]           coef_select = '0;
  logic signed [bqiir_pkg::COEF_W-1:0]   coef_value = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [bqiir_pkg::SAMPLE_W-1:0] sample_out;
  logic                                  clipped;
  logic                                  cfg_we = 1'b0;
  logic [bqiir_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [bqiir_pkg::CFG_W-1:0]           cfg_data = '0;

  // filter model state
  logic signed [bqiir_pkg::COEF_W-1:0] coef_bank [bqiir_pkg::COEFS*MAX_SECTIONS];
  logic signed [bqiir_pkg::INT_W-1:0]  delay_bank [2*MAX_SECTIONS];
  logic signed [bqiir_pkg::COEF_W-1:0] gain_reg;
  logic [bqiir_pkg::ACT_W-1:0]         active_reg;
  bit                                  clip_seen;

  out_item_t pending_out[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;

  biquad_cascade_iir_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .sample_in     (sample_in),
    .section_index (section_index),
    .coef_select   (coef_select),
    .coef_value    (coef_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .clipped       (clipped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Q3.29 times Q9.31, rounded half up back to Q9.31
  function automatic longint scale_by_coef(input longint c, input longint d);
    logic signed [127:0] p;
    p = 128'(c);
    p = p * 128'(d);
    p = p + (128'sd1 <<< (bqiir_pkg::COEF_SHIFT - 1));
    return longint'(p >>> bqiir_pkg::COEF_SHIFT);
  endfunction

  function automatic longint coef_of(input int s, input logic [bqiir_pkg::SEL_W-1:0] sel);
    return longint'(coef_bank[s * bqiir_pkg::COEFS + int'(sel)]);
  endfunction

  task automatic reset_model();
    foreach (coef_bank[i]) coef_bank[i] = '0;
    foreach (delay_bank[i]) delay_bank[i] = '0;
    gain_reg   = bqiir_pkg::GAIN_RESET;
    active_reg = bqiir_pkg::ACTIVE_RESET;
  endtask

  task automatic store_coef(input logic [bqiir_pkg::SEC_IN_W-1:0] sec,
                            input logic [bqiir_pkg::SEL_W-1:0] sel,
                            input logic signed [bqiir_pkg::COEF_W-1:0] val);
    if (int'(sel) < bqiir_pkg::COEFS && int'(sec) < MAX_SECTIONS)
      coef_bank[int'(sec) * bqiir_pkg::COEFS + int'(sel)] = val;
  endtask

  task automatic filter_sample(input logic signed [bqiir_pkg::SAMPLE_W-1:0] smp);
    longint    acc;
    longint    w;
    longint    d1;
    longint    d2;
    int        n;
    out_item_t res;
    clip_seen = 1'b0;
    acc = longint'(smp);
    acc = saturate((acc * longint'(gain_reg) + (longint'(1) <<< (bqiir_pkg::GAIN_SHIFT - 1)))
                   >>> bqiir_pkg::GAIN_SHIFT, bqiir_pkg::INT_W);
    n = (int'(active_reg) > MAX_SECTIONS) ? MAX_SECTIONS : int'(active_reg);
    for (int s = 0; s < n; s++) begin
      d1 = longint'(delay_bank[2*s]);
      d2 = longint'(delay_bank[2*s+1]);
      w = saturate(acc - scale_by_coef(coef_of(s, bqiir_pkg::COEF_A1), d1)
                       - scale_by_coef(coef_of(s, bqiir_pkg::COEF_A2), d2), bqiir_pkg::INT_W);
      acc = saturate(scale_by_coef(coef_of(s, bqiir_pkg::COEF_B0), w)
                   + scale_by_coef(coef_of(s, bqiir_pkg::COEF_B1), d1)
                   + scale_by_coef(coef_of(s, bqiir_pkg::COEF_B2), d2), bqiir_pkg::INT_W);
      delay_bank[2*s+1] = bqiir_pkg::INT_W'(d1);
      delay_bank[2*s]   = bqiir_pkg::INT_W'(w);
    end
    res.sample = bqiir_pkg::SAMPLE_W'(
                   saturate((acc + (longint'(1) <<< (bqiir_pkg::OUT_SHIFT - 1)))
                            >>> bqiir_pkg::OUT_SHIFT, bqiir_pkg::SAMPLE_W));
    res.clip   = clip_seen;
    pending_out.push_back(res);
  endtask

  // one item on the input channel, with bursty pacing
  task automatic send_item(input logic op_v,
                           input logic signed [bqiir_pkg::SAMPLE_W-1:0] smp,
                           input logic [bqiir_pkg::SEC_IN_W-1:0] sec,
                           input logic [bqiir_pkg::SEL_W-1:0] sel,
                           input logic signed [bqiir_pkg::COEF_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    op            <= op_v;
    sample_in     <= smp;
    section_index <= sec;
    coef_select   <= sel;
    coef_value    <= val;
    do @(posedge clk); while (in_stall);
    if (op_v == bqiir_pkg::OP_COEF)
      store_coef(sec, sel, val);
    else
      filter_sample(smp);
  endtask

  task automatic send_sample(input logic signed [bqiir_pkg::SAMPLE_W-1:0] smp);
    send_item(bqiir_pkg::OP_FILTER, smp, bqiir_pkg::SEC_IN_W'($urandom()),
              bqiir_pkg::SEL_W'($urandom()), $urandom());
  endtask

  task automatic send_coef(input logic [bqiir_pkg::SEC_IN_W-1:0] sec,
                           input logic [bqiir_pkg::SEL_W-1:0] sel,
                           input logic signed [bqiir_pkg::COEF_W-1:0] val);
    send_item(bqiir_pkg::OP_COEF, bqiir_pkg::SAMPLE_W'($urandom()), sec, sel, val);
  endtask

  // drain all results, then let the block finish any write in flight
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [bqiir_pkg::CFG_W-1:0] gain_word,
                           input logic [bqiir_pkg::ACT_W-1:0] act);
    cfg_we    <= 1'b1;
    cfg_index <= bqiir_pkg::REG_INPUT_GAIN;
    cfg_data  <= gain_word;
    @(posedge clk);
    gain_reg = gain_word;
    cfg_index <= bqiir_pkg::REG_ACTIVE_SECTIONS;
    cfg_data  <= {28'($urandom()), act};
    @(posedge clk);
    active_reg = act;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [bqiir_pkg::COEF_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return bqiir_pkg::GAIN_RESET;
    endcase
  endfunction

  function automatic logic signed [bqiir_pkg::COEF_W-1:0] rand_coef();
    logic signed [bqiir_pkg::COEF_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return pick_extreme();
      default: begin
        v = $urandom_range(0, 32'h2000_0000);
        return v - 32'sh1000_0000;
      end
    endcase
  endfunction

  function automatic logic signed [bqiir_pkg::SAMPLE_W-1:0] rand_sample();
    logic signed [bqiir_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 24'sh7F_FFFF;
          1:       return 24'sh80_0000;
          2:       return 24'sh00_0000;
          default: return 24'shFF_FFFF;
        endcase
      end
      1: begin
        v = bqiir_pkg::SAMPLE_W'($urandom_range(0, 65535));
        return v - 24'sd32768;
      end
      default: return bqiir_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [bqiir_pkg::CFG_W-1:0] rand_gain();
    logic signed [bqiir_pkg::CFG_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       return bqiir_pkg::GAIN_RESET;
      1:       return $urandom();
      2:       return pick_extreme();
      default: begin
        v = $urandom_range(0, 32'h4000_0000);
        return v - 32'sh2000_0000;
      end
    endcase
  endfunction

  // all coefficients are zero after reset, so every output is zero
  task automatic test_reset_defaults();
    send_sample(24'sh7F_FFFF);
    send_sample(24'sh80_0000);
    send_sample(24'sh00_0000);
  endtask

  task automatic test_coef_writes();
    send_coef(3'd0, bqiir_pkg::COEF_B0, 32'sh2000_0000);
    send_coef(3'd0, COEF_BAD_LO, 32'sh7FFF_FFFF);
    send_coef(3'd0, COEF_BAD_HI, 32'sh8000_0000);
    send_sample(24'sh7F_FFFF);
    send_sample(24'sh80_0000);
    send_coef(3'd0, bqiir_pkg::COEF_B1, 32'sh7FFF_FFFF);
    send_coef(3'd0, bqiir_pkg::COEF_B2, 32'sh8000_0000);
    send_coef(3'd0, bqiir_pkg::COEF_A1, 32'sh1000_0000);
    send_coef(3'd0, bqiir_pkg::COEF_A2, 32'shF000_0000);
    send_sample(24'shFF_FFFF);
    send_sample(24'sh00_0001);
    send_sample(24'sh7F_FFFF);
  endtask

  task automatic test_section_counts();
    // no sections: scaled input straight to the output
    wait_for_idle();
    configure(32'h7FFF_FFFF, 4'd0);
    send_sample(24'sh7F_FFFF);
    send_sample(24'sh80_0000);
    // count above the maximum is clamped
    wait_for_idle();
    configure(32'h8000_0000, 4'd15);
    send_sample(24'sh7F_FFFF);
    send_sample(24'sh00_0000);
  endtask

  // strong feedback drives the delay line into saturation
  task automatic test_internal_overflow();
    wait_for_idle();
    configure(32'h7FFF_FFFF, 4'd1);
    send_coef(3'd0, bqiir_pkg::COEF_A1, 32'sh8000_0000);
    send_coef(3'd0, bqiir_pkg::COEF_A2, 32'sh0000_0000);
    repeat (4) send_sample(24'sh7F_FFFF);
  endtask

  task automatic test_random_phases();
    logic [bqiir_pkg::ACT_W-1:0] act;
    int                          used;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        1:       act = 4'd0;
        3:       act = 4'd8;
        6:       act = 4'd15;
        default: act = bqiir_pkg::ACT_W'($urandom_range(1, 3));
      endcase
      wait_for_idle();
      configure(rand_gain(), act);
      used = (int'(act) > MAX_SECTIONS) ? MAX_SECTIONS : int'(act);
      for (int s = 0; s < used; s++) begin
        send_coef(bqiir_pkg::SEC_IN_W'(s), bqiir_pkg::COEF_B0, rand_coef());
        send_coef(bqiir_pkg::SEC_IN_W'(s), bqiir_pkg::COEF_B1, rand_coef());
        send_coef(bqiir_pkg::SEC_IN_W'(s), bqiir_pkg::COEF_B2, rand_coef());
        send_coef(bqiir_pkg::SEC_IN_W'(s), bqiir_pkg::COEF_A1, rand_coef());
        send_coef(bqiir_pkg::SEC_IN_W'(s), bqiir_pkg::COEF_A2, rand_coef());
      end
      for (int k = 0; k < 43; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_coef(bqiir_pkg::SEC_IN_W'($urandom()), bqiir_pkg::SEL_W'($urandom()),
                    rand_coef());
        else
          send_sample(rand_sample());
      end
    end
  endtask

  // output stall in changing patterns, including stretches with none
  initial begin : stall_pattern
    int left;
    int mode;
    int tick;
    left = 0;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      tick++;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((tick % 9) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        $error("unexpected result: sample_out %0d clipped %0b", sample_out, clipped);
        fail_count++;
      end else begin
        want = pending_out.pop_front();
        if (sample_out !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
          fail_count++;
        end
        if (clipped !== want.clip) begin
          $error("clipped: expected %0b, got %0b", want.clip, clipped);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_coef_writes();
    test_section_counts();
    test_internal_overflow();
    test_random_phases();
    wait_for_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
